[rtl/pcac_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcac_pkg
// shared types and constants of the per-class alert coalescer
// ----------------------------------------------------------------------------
package pcac_pkg;

  localparam int CLASS_COUNT_DEF = 16;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACKER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEARBY  = 2'd2;

  localparam logic [15:0] WINDOW_RST  = 16'd2500;
  localparam logic [7:0]  TRACKER_RST = 8'd5;
  localparam logic [7:0]  NEARBY_RST  = 8'd10;

  localparam logic [1:0] CMD_DETECT   = 2'd0;
  localparam logic [1:0] CMD_CONNECT  = 2'd1;
  localparam logic [1:0] CMD_TEST     = 2'd2;
  localparam logic [1:0] CMD_POWER_ON = 2'd3;

  localparam logic [7:0] CODE_REVEAL   = 8'hFC;
  localparam logic [7:0] CODE_CONNECT  = 8'hFD;
  localparam logic [7:0] CODE_TEST     = 8'hFE;
  localparam logic [7:0] CODE_POWER_ON = 8'hFB;

  typedef struct packed {
    logic       emit;
    logic [7:0] code;
    logic       stamp;
    logic       disarm;
    logic       arm;
  } dec_t;

endpackage

[rtl/pcac_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcac_ram
// generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module pcac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/pcac_decide.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcac_decide
// per-item decision: reveal, coalesce window check, fixed codes
// ----------------------------------------------------------------------------
module pcac_decide
  import pcac_pkg::*;
(
  input  logic [1:0]  cmd,
  input  logic [7:0]  device_class,
  input  logic        is_new,
  input  logic [31:0] now_ms,
  input  logic [31:0] last_ms,
  input  logic        in_range,
  input  logic        armed,
  input  logic [15:0] window_ms,
  input  logic [7:0]  tracker_class,
  input  logic [7:0]  nearby_class,
  output dec_t        dec
);

  logic [31:0] diff;
  logic        suppress;
  logic        reveal;

  assign diff     = now_ms - last_ms;
  assign suppress = (last_ms != 32'd0) && (diff < {16'd0, window_ms});
  assign reveal   = armed && (device_class != tracker_class) &&
                    (device_class != nearby_class);

  always_comb begin
    dec = '0;
    case (cmd)
      CMD_CONNECT: begin
        dec.emit = 1'b1;
        dec.code = CODE_CONNECT;
        dec.arm  = 1'b1;
      end
      CMD_TEST: begin
        dec.emit = 1'b1;
        dec.code = CODE_TEST;
      end
      CMD_POWER_ON: begin
        dec.emit = 1'b1;
        dec.code = CODE_POWER_ON;
      end
      CMD_DETECT: begin
        if (is_new) begin
          if (reveal) begin
            dec.emit   = 1'b1;
            dec.code   = CODE_REVEAL;
            dec.disarm = 1'b1;
            dec.stamp  = in_range;
          end else if (!in_range) begin
            dec.emit = 1'b1;
            dec.code = device_class;
          end else if (!suppress) begin
            dec.emit  = 1'b1;
            dec.code  = device_class;
            dec.stamp = 1'b1;
          end
        end
      end
      default: begin
        dec = '0;
      end
    endcase
  end

endmodule

[rtl/per_class_alert_coalescer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_class_alert_coalescer
// per-class alert coalescing with a one-shot reveal
// ----------------------------------------------------------------------------
// Takes one item per clock cycle with no bubbles while out_ready is high; a low
// out_ready stalls the pipeline. An accepted item is captured in the input
// register together with the registered read of the last-alert-time RAM, and
// its decision is then captured in the output register. The table of last alert
// times sits in a RAM of CLASS_COUNT words; per-entry valid flops cleared by
// reset make unwritten classes read as "never alerted", so no clearing pass
// is needed. A write to the class that the next item reads is forwarded.
// Configuration writes take effect on the next item decided.
// ----------------------------------------------------------------------------
module per_class_alert_coalescer
  import pcac_pkg::*;
#(
  parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_cmd,
  input  logic [7:0]            in_device_class,
  input  logic                  in_is_new,
  input  logic [31:0]           in_now_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_emit,
  output logic [7:0]            out_alert_code,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

  logic [15:0] window_r;
  logic [7:0]  tracker_r;
  logic [7:0]  nearby_r;
  logic        armed_r;
  logic        armed_nxt;

  logic        s1_valid_r;
  logic [1:0]  s1_cmd_r;
  logic [7:0]  s1_class_r;
  logic        s1_new_r;
  logic [31:0] s1_now_r;
  logic        s1_seen_r;
  logic        s1_fwd_r;
  logic [31:0] s1_fwd_data_r;

  logic        out_valid_r;
  logic        out_emit_r;
  logic [7:0]  out_code_r;

  logic [CLASS_COUNT-1:0] seen_r;

  logic              accept;
  logic              s1_adv;
  logic              in_in_range;
  logic              s1_in_range;
  logic [IDX_W-1:0]  in_idx;
  logic [IDX_W-1:0]  s1_idx;
  logic              wr_en;
  logic [31:0]       rd_data;
  logic [31:0]       last_ms;
  dec_t              dec;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  assign in_in_range = {1'b0, in_device_class} < 9'(CLASS_COUNT);
  assign s1_in_range = {1'b0, s1_class_r} < 9'(CLASS_COUNT);
  assign in_idx      = in_device_class[IDX_W-1:0];
  assign s1_idx      = s1_class_r[IDX_W-1:0];
  assign wr_en       = s1_adv && dec.stamp;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= WINDOW_RST;
      tracker_r <= TRACKER_RST;
      nearby_r  <= NEARBY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW:  window_r  <= cfg_wdata[15:0];
        REG_TRACKER: tracker_r <= cfg_wdata[7:0];
        REG_NEARBY:  nearby_r  <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  pcac_ram #(
    .WIDTH (32),
    .DEPTH (CLASS_COUNT),
    .AW    (IDX_W)
  ) u_time_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_idx),
    .wdata (s1_now_r),
    .re    (accept),
    .raddr (in_idx),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (wr_en) begin
      seen_r[s1_idx] <= 1'b1;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r      <= in_cmd;
      s1_class_r    <= in_device_class;
      s1_new_r      <= in_is_new;
      s1_now_r      <= in_now_ms;
      s1_seen_r     <= in_in_range && seen_r[in_idx];
      s1_fwd_r      <= wr_en && in_in_range && (s1_idx == in_idx);
      s1_fwd_data_r <= s1_now_r;
    end
  end

  assign last_ms = s1_fwd_r  ? s1_fwd_data_r :
                   s1_seen_r ? rd_data : 32'd0;

  pcac_decide u_decide (
    .cmd           (s1_cmd_r),
    .device_class  (s1_class_r),
    .is_new        (s1_new_r),
    .now_ms        (s1_now_r),
    .last_ms       (last_ms),
    .in_range      (s1_in_range),
    .armed         (armed_r),
    .window_ms     (window_r),
    .tracker_class (tracker_r),
    .nearby_class  (nearby_r),
    .dec           (dec)
  );

  always_comb begin
    armed_nxt = armed_r;
    if (s1_adv) begin
      if (dec.arm) begin
        armed_nxt = 1'b1;
      end else if (dec.disarm) begin
        armed_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b1;
    end else begin
      armed_r <= armed_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_emit_r <= dec.emit;
      out_code_r <= dec.code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_emit       = out_emit_r;
  assign out_alert_code = out_code_r;

  a_reveal_disarms : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_cmd_r == CMD_DETECT) && s1_new_r && armed_r &&
     (s1_class_r != tracker_r) && (s1_class_r != nearby_r))
      |=> !armed_r)
    else $error("reveal did not clear the armed flag");

  a_connect_arms : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_cmd_r == CMD_CONNECT)) |=> armed_r)
    else $error("connect did not re-arm the reveal");

  a_quiet_code_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_emit_r) |-> (out_code_r == 8'd0))
    else $error("suppressed item carries a nonzero code");

  a_stamp_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (s1_in_range && s1_new_r && (s1_cmd_r == CMD_DETECT)))
    else $error("table written by an item that may not stamp");

endmodule
